>>> src/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
// Included by the top level; no other dependencies.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAU_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg)
`define CAU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

>>> src/cau_pkg.sv
// Shared types, widths and helper functions of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int DEN_BITS  = PROD_BITS;
  localparam int DVS_BITS  = DEN_BITS + 1;
  localparam int QUO_BITS  = WORD_BITS + 1;
  localparam int REM_BITS  = DVS_BITS + QUO_BITS;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX =
    {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [QUO_BITS-1:0] QUO_LIM = QUO_BITS'(1) << (WORD_BITS - 1);

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_NEG   = 3'd4,
    CMD_CONJ  = 3'd5,
    CMD_SCALE = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_re;
    logic signed [WORD_BITS-1:0] r_im;
    logic                        div_zero;
    logic                        overflow;
  } cau_out_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        ovf;
  } sat_t;

  // One beat in flight through the divider array
  typedef struct packed {
    logic                        valid;
    logic                        is_div;
    logic                        div_zero;
    logic signed [WORD_BITS-1:0] fix_re;
    logic signed [WORD_BITS-1:0] fix_im;
    logic                        fix_ovf;
    logic                        neg_re;
    logic                        neg_im;
    logic                        qov_re;
    logic                        qov_im;
    logic [REM_BITS-1:0]         rem_re;
    logic [REM_BITS-1:0]         rem_im;
    logic [DVS_BITS-1:0]         dvs;
    logic [QUO_BITS-1:0]         quo_re;
    logic [QUO_BITS-1:0]         quo_im;
  } cau_div_t;

  // Clamp an exact value to the word range
  function automatic sat_t saturate(input logic signed [SUM_BITS-1:0] v);
    sat_t s;
    if (v > SUM_MAX) begin
      s.val = WORD_MAX;
      s.ovf = 1'b1;
    end else if (v < SUM_MIN) begin
      s.val = WORD_MIN;
      s.ovf = 1'b1;
    end else begin
      s.val = v[WORD_BITS-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // Drop the fraction bits, round to nearest, ties away from zero
  function automatic logic signed [SUM_BITS-1:0] round_frac(
      input logic signed [SUM_BITS-1:0] x);
    logic                neg;
    logic [SUM_BITS-1:0] mag;
    logic [SUM_BITS-1:0] m;
    neg = x[SUM_BITS-1];
    mag = neg ? SUM_BITS'(-x) : SUM_BITS'(x);
    m   = (mag + ROUND_HALF) >> FRAC_BITS;
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // Apply sign and clamp to an unsigned quotient magnitude
  function automatic sat_t quo_sat(input logic [QUO_BITS-1:0] q, input logic qov,
                                   input logic neg);
    sat_t s;
    if (neg) begin
      if (qov || (q > QUO_LIM)) begin
        s.val = WORD_MIN;
        s.ovf = 1'b1;
      end else begin
        s.val = WORD_BITS'(-q);
        s.ovf = 1'b0;
      end
    end else begin
      if (qov || (q >= QUO_LIM)) begin
        s.val = WORD_MAX;
        s.ovf = 1'b1;
      end else begin
        s.val = WORD_BITS'(q);
        s.ovf = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

>>> src/cau_front.sv
// Front end: products, per-operation sums, rounding and divide setup.
// Three register stages; depends on cau_pkg.
module cau_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  cau_pkg::cau_in_t in_data,
  output cau_pkg::cau_div_t dv_o
);
  import cau_pkg::*;

  // Stage 1: operand copies and products
  logic                          v1_r;
  logic [2:0]                    cmd1_r;
  logic signed [WORD_BITS-1:0]   a_re1_r, a_im1_r, b_re1_r, b_im1_r;
  logic signed [PROD_BITS-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= in_data.cmd;
      a_re1_r <= in_data.a_re;
      a_im1_r <= in_data.a_im;
      b_re1_r <= in_data.b_re;
      b_im1_r <= in_data.b_im;
      p_rr_r  <= in_data.a_re * in_data.b_re;
      p_ii_r  <= in_data.a_im * in_data.b_im;
      p_ri_r  <= in_data.a_re * in_data.b_im;
      p_ir_r  <= in_data.a_im * in_data.b_re;
      p_bb_r  <= in_data.b_re * in_data.b_re;
      p_cc_r  <= in_data.b_im * in_data.b_im;
    end
  end

  // Stage 2: exact sums for each operation
  logic                        v2_r;
  logic [2:0]                  cmd2_r;
  logic signed [SUM_BITS-1:0]  sum_re_r, sum_im_r, sum_re_nxt, sum_im_nxt;
  logic [DEN_BITS-1:0]         den_r, den_nxt;

  always_comb begin
    sum_re_nxt = '0;
    sum_im_nxt = '0;
    den_nxt    = DEN_BITS'(p_bb_r) + DEN_BITS'(p_cc_r);
    case (cmd1_r)
      CMD_ADD: begin
        sum_re_nxt = SUM_BITS'(a_re1_r) + SUM_BITS'(b_re1_r);
        sum_im_nxt = SUM_BITS'(a_im1_r) + SUM_BITS'(b_im1_r);
      end
      CMD_SUB: begin
        sum_re_nxt = SUM_BITS'(a_re1_r) - SUM_BITS'(b_re1_r);
        sum_im_nxt = SUM_BITS'(a_im1_r) - SUM_BITS'(b_im1_r);
      end
      CMD_MUL: begin
        sum_re_nxt = SUM_BITS'(p_rr_r) - SUM_BITS'(p_ii_r);
        sum_im_nxt = SUM_BITS'(p_ri_r) + SUM_BITS'(p_ir_r);
      end
      CMD_DIV: begin
        sum_re_nxt = SUM_BITS'(p_rr_r) + SUM_BITS'(p_ii_r);
        sum_im_nxt = SUM_BITS'(p_ir_r) - SUM_BITS'(p_ri_r);
      end
      CMD_NEG: begin
        sum_re_nxt = -SUM_BITS'(a_re1_r);
        sum_im_nxt = -SUM_BITS'(a_im1_r);
      end
      CMD_CONJ: begin
        sum_re_nxt = SUM_BITS'(a_re1_r);
        sum_im_nxt = -SUM_BITS'(a_im1_r);
      end
      CMD_SCALE: begin
        sum_re_nxt = SUM_BITS'(p_rr_r);
        sum_im_nxt = SUM_BITS'(p_ir_r);
      end
      default: begin
        sum_re_nxt = '0;
        sum_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r   <= cmd1_r;
      sum_re_r <= sum_re_nxt;
      sum_im_r <= sum_im_nxt;
      den_r    <= den_nxt;
    end
  end

  // Stage 3: round and clamp direct results, set up the divide
  cau_div_t                    dv_r, dv_nxt;
  logic signed [SUM_BITS-1:0]  fre, fim;
  sat_t                        sre, sim;
  logic [SUM_BITS-1:0]         mag_re, mag_im;
  logic [REM_BITS-1:0]         bound;

  always_comb begin
    if (cmd2_r inside {CMD_MUL, CMD_SCALE}) begin
      fre = round_frac(sum_re_r);
      fim = round_frac(sum_im_r);
    end else begin
      fre = sum_re_r;
      fim = sum_im_r;
    end
    sre = saturate(fre);
    sim = saturate(fim);
    mag_re = sum_re_r[SUM_BITS-1] ? SUM_BITS'(-sum_re_r) : SUM_BITS'(sum_re_r);
    mag_im = sum_im_r[SUM_BITS-1] ? SUM_BITS'(-sum_im_r) : SUM_BITS'(sum_im_r);

    dv_nxt          = '0;
    dv_nxt.valid    = v2_r;
    dv_nxt.is_div   = (cmd2_r == CMD_DIV);
    dv_nxt.div_zero = (cmd2_r == CMD_DIV) && (den_r == '0);
    dv_nxt.fix_re   = sre.val;
    dv_nxt.fix_im   = sim.val;
    dv_nxt.fix_ovf  = sre.ovf | sim.ovf;
    dv_nxt.neg_re   = sum_re_r[SUM_BITS-1];
    dv_nxt.neg_im   = sum_im_r[SUM_BITS-1];
    dv_nxt.dvs      = {den_r, 1'b0};
    dv_nxt.rem_re   = (REM_BITS'(mag_re) << (FRAC_BITS + 1)) + REM_BITS'(den_r);
    dv_nxt.rem_im   = (REM_BITS'(mag_im) << (FRAC_BITS + 1)) + REM_BITS'(den_r);
    bound           = REM_BITS'(dv_nxt.dvs) << QUO_BITS;
    dv_nxt.qov_re   = dv_nxt.rem_re >= bound;
    dv_nxt.qov_im   = dv_nxt.rem_im >= bound;
    dv_nxt.quo_re   = '0;
    dv_nxt.quo_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.valid <= 1'b0;
    end else if (en) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv_o = dv_r;

endmodule

>>> src/cau_div_step.sv
// One restoring-divide step: one quotient bit for each part per stage.
// Depends on cau_pkg.
module cau_div_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  cau_pkg::cau_div_t dv_i,
  output cau_pkg::cau_div_t dv_o
);
  import cau_pkg::*;

  cau_div_t            dv_r, dv_nxt;
  logic [REM_BITS-1:0] trial;
  logic                bit_re, bit_im;

  // Compare against the divisor at the top quotient weight, then shift
  always_comb begin
    trial  = REM_BITS'(dv_i.dvs) << (QUO_BITS - 1);
    bit_re = dv_i.rem_re >= trial;
    bit_im = dv_i.rem_im >= trial;
    dv_nxt = dv_i;
    dv_nxt.rem_re = (bit_re ? (dv_i.rem_re - trial) : dv_i.rem_re) << 1;
    dv_nxt.rem_im = (bit_im ? (dv_i.rem_im - trial) : dv_i.rem_im) << 1;
    dv_nxt.quo_re = {dv_i.quo_re[QUO_BITS-2:0], bit_re};
    dv_nxt.quo_im = {dv_i.quo_im[QUO_BITS-2:0], bit_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.valid <= 1'b0;
    end else if (en) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv_o = dv_r;

endmodule

>>> src/complex_arith_unit.sv
// Top level of the pipelined fixed-point complex arithmetic unit.
// Depends on cau_pkg, cau_front, cau_div_step and the assertion macros.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | cau_in_t  (cmd, a_re, a_im, b_re, b_im)
//   out     | output    | out_valid/out_stall| cau_out_t (r_re, r_im, div_zero, overflow)
//
// Beats enter one per cycle unless stalled and pass three front-end stages,
// 33 divide stages (one quotient bit per stage) and the output register.
// Every operation takes the same path so results leave in order.
// Reset clears only the valid bits. A stalled output beat freezes the
// whole pipeline, and in_stall follows it in the same cycle.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cau_pkg::cau_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cau_pkg::cau_out_t  out_data
);
  import cau_pkg::*;

  logic     en;
  logic     out_valid_r;
  cau_out_t out_r, out_nxt;
  cau_div_t stage_w [QUO_BITS+1];
  cau_div_t last;
  sat_t     qre, qim;

  // Advance everything unless the output beat is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .dv_o     (stage_w[0])
  );

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    cau_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dv_i  (stage_w[g]),
      .dv_o  (stage_w[g+1])
    );
  end

  // Pick the direct or the divide result
  always_comb begin
    last = stage_w[QUO_BITS];
    qre  = quo_sat(last.quo_re, last.qov_re, last.neg_re);
    qim  = quo_sat(last.quo_im, last.qov_im, last.neg_im);
    if (!last.is_div) begin
      out_nxt.r_re     = last.fix_re;
      out_nxt.r_im     = last.fix_im;
      out_nxt.div_zero = 1'b0;
      out_nxt.overflow = last.fix_ovf;
    end else if (last.div_zero) begin
      out_nxt.r_re     = WORD_MAX;
      out_nxt.r_im     = WORD_MAX;
      out_nxt.div_zero = 1'b1;
      out_nxt.overflow = 1'b0;
    end else begin
      out_nxt.r_re     = qre.val;
      out_nxt.r_im     = qim.val;
      out_nxt.div_zero = 1'b0;
      out_nxt.overflow = qre.ovf | qim.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CAU_ASSERT_SAME(a_dz_no_ovf, clk, rst_n, out_valid && out_data.div_zero,
                   !out_data.overflow, "div_zero beat with overflow set")
  `CAU_ASSERT_SAME(a_dz_max, clk, rst_n, out_valid && out_data.div_zero,
                   (out_data.r_re == WORD_MAX) && (out_data.r_im == WORD_MAX),
                   "div_zero beat not saturated to max")
  `CAU_ASSERT_NEXT(a_hold_front, clk, rst_n, out_valid && out_stall,
                   $stable(stage_w[0]), "front end moved during output stall")

endmodule

>>> tb/tb_complex_arith_unit.sv
// Self-checking testbench for the complex arithmetic unit.
// Depends on cau_pkg and complex_arith_unit.
module tb_complex_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef logic signed [127:0] wide_t;

  // Holds expected results in order and compares each result beat against them
  class cau_scoreboard;
    cau_out_t expected_q[$];
    int       errors;
    int       checked;
    int       zero_divs;
    int       saturations;

    function wide_t round_q(wide_t x);
      wide_t m;
      logic  neg;
      neg = x < 0;
      m   = neg ? -x : x;
      m   = (m + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return neg ? -m : m;
    endfunction

    function wide_t div_nearest(wide_t num, wide_t den);
      wide_t m;
      wide_t q;
      logic  neg;
      m   = num <<< FRAC_BITS;
      neg = m < 0;
      if (neg) m = -m;
      q = (2 * m + den) / (2 * den);
      return neg ? -q : q;
    endfunction

    function logic signed [WORD_BITS-1:0] clamp(wide_t x, inout logic ovf);
      wide_t hi;
      wide_t lo;
      hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
      lo = -(wide_t'(1) <<< (WORD_BITS - 1));
      if (x > hi) begin
        ovf = 1'b1;
        return WORD_MAX;
      end
      if (x < lo) begin
        ovf = 1'b1;
        return WORD_MIN;
      end
      return x[WORD_BITS-1:0];
    endfunction

    function cau_out_t complex_result(cau_in_t x);
      wide_t    ar, ai, br, bi, re, im, den;
      cau_out_t r;
      logic     ovf;
      ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
      re = 0; im = 0; ovf = 1'b0;
      r = '0;
      case (x.cmd)
        CMD_ADD: begin re = ar + br; im = ai + bi; end
        CMD_SUB: begin re = ar - br; im = ai - bi; end
        CMD_MUL: begin
          re = round_q(ar * br - ai * bi);
          im = round_q(ar * bi + ai * br);
        end
        CMD_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.r_re = WORD_MAX;
            r.r_im = WORD_MAX;
            r.div_zero = 1'b1;
            return r;
          end
          re = div_nearest(ar * br + ai * bi, den);
          im = div_nearest(ai * br - ar * bi, den);
        end
        CMD_NEG:   begin re = -ar; im = -ai; end
        CMD_CONJ:  begin re = ar; im = -ai; end
        CMD_SCALE: begin re = round_q(ar * br); im = round_q(ai * br); end
        default: ;
      endcase
      r.r_re = clamp(re, ovf);
      r.r_im = clamp(im, ovf);
      r.overflow = ovf;
      return r;
    endfunction

    // Note an accepted input beat
    function void note_input(cau_in_t x);
      cau_out_t e;
      e = complex_result(x);
      if (e.div_zero) zero_divs++;
      if (e.overflow) saturations++;
      expected_q.push_back(e);
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(cau_out_t got);
      cau_out_t e;
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.r_re !== e.r_re)
        $display("%0t: r_re expected %h actual %h", $realtime, e.r_re, got.r_re);
      if (got.r_im !== e.r_im)
        $display("%0t: r_im expected %h actual %h", $realtime, e.r_im, got.r_im);
      if (got.div_zero !== e.div_zero)
        $display("%0t: div_zero expected %b actual %b", $realtime, e.div_zero,
                 got.div_zero);
      if (got.overflow !== e.overflow)
        $display("%0t: overflow expected %b actual %b", $realtime, e.overflow,
                 got.overflow);
      if (got !== e) errors++;
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cau_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cau_out_t out_data;

  cau_scoreboard sb = new();
  int stall_mode = 0;
  int cyc = 0;

  complex_arith_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Check result beats and drive out_stall from a randomly picked stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    cyc <= cyc + 1;
    if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ((cyc % 16) < 10);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Hold one beat until it is taken
  task automatic send_beat(cau_in_t x);
    in_data  <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(x);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_op(logic [2:0] c, logic [31:0] ar, logic [31:0] ai,
                         logic [31:0] br, logic [31:0] bi);
    cau_in_t x;
    x.cmd = c; x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi;
    send_beat(x);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5, 6: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      7: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      default: begin
        case ($urandom_range(0, 5))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return 32'd0;
          3: return 32'd1;
          4: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  initial begin
    int burst;
    logic [2:0] c;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes for every operation, special cases
    send_op(CMD_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    send_op(CMD_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    send_op(CMD_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN);
    send_op(CMD_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_op(CMD_MUL, 32'h0000_8000, 32'd0, 32'h0000_0001, 32'd0);
    send_op(CMD_MUL, 32'hffff_8000, 32'd0, 32'h0000_0001, 32'd0);
    send_op(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
    send_op(CMD_DIV, WORD_MAX, WORD_MIN, 32'd1, 32'd0);
    send_op(CMD_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_op(CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
    send_op(CMD_DIV, 32'h0000_0001, 32'd0, 32'h0003_0000, 32'd0);
    send_op(CMD_NEG, WORD_MIN, WORD_MAX, 32'd5, 32'd7);
    send_op(CMD_NEG, 32'd0, WORD_MIN, 32'd0, 32'd0);
    send_op(CMD_CONJ, WORD_MIN, WORD_MIN, 32'd0, 32'd0);
    send_op(CMD_CONJ, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_op(CMD_SCALE, WORD_MAX, WORD_MIN, WORD_MIN, 32'd0);
    send_op(CMD_SCALE, 32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 32'd0);
    send_op(CMD_UNUSED, WORD_MAX, WORD_MIN, 32'hffff_ffff, 32'd1);
    idle_cycles(3);

    // Random bursts; pause for a full drain partway through
    for (int i = 0; i < 800; i++) begin
      c = ($urandom_range(0, 29) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
      send_op(c, pick_word(), pick_word(),
              ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word(),
              ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word());
      if (i == 400) begin
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
      end else begin
        burst = burst - 1;
        if (burst <= 0) begin
          burst = $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d results over all operations and unused code; %0d zero divisors,",
             sb.checked, sb.zero_divs);
    $display("%0d saturated results, bursty input and patterned output stalls.",
             sb.saturations);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_complex_arith_unit: PASS");
    end else begin
      $display("tb_complex_arith_unit: FAIL");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    #2ms;
    $display("tb_complex_arith_unit: FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+src
src/cau_pkg.sv
src/cau_front.sv
src/cau_div_step.sv
src/complex_arith_unit.sv
tb/tb_complex_arith_unit.sv
